FILE: hw/rtl/tsu_pkg.sv
// Shared types and constants of the triplet STDP synapse update block.
package tsu_pkg;

	localparam int DEF_NUM_SYNAPSES = 1024;
	localparam int DEF_TRACE_BITS   = 20;

	localparam int SYN_W    = 10;
	localparam int WEIGHT_W = 17;
	localparam int FACTOR_W = 16;
	localparam int CFG_NUM  = 8;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [WEIGHT_W-1:0] W_ONE = 17'h10000;

	localparam logic [FACTOR_W-1:0] CFG_RESET [CFG_NUM] = '{
		16'd61750, 16'd64891, 16'd63620, 16'd65014,
		16'd328, 16'd406, 16'd459, 16'd15
	};

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_PRE  = 2'd1,
		REQ_POST = 2'd2,
		REQ_LOAD = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_DECAY_FAST_PRE  = 3'd0,
		CFG_DECAY_SLOW_PRE  = 3'd1,
		CFG_DECAY_FAST_POST = 3'd2,
		CFG_DECAY_SLOW_POST = 3'd3,
		CFG_PAIR_POT        = 3'd4,
		CFG_TRIPLET_POT     = 3'd5,
		CFG_PAIR_DEP        = 3'd6,
		CFG_TRIPLET_DEP     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] decay_fast_pre;
		logic [FACTOR_W-1:0] decay_slow_pre;
		logic [FACTOR_W-1:0] decay_fast_post;
		logic [FACTOR_W-1:0] decay_slow_post;
		logic [FACTOR_W-1:0] pair_potentiation;
		logic [FACTOR_W-1:0] triplet_potentiation;
		logic [FACTOR_W-1:0] pair_depression;
		logic [FACTOR_W-1:0] triplet_depression;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPK_RD,
		ST_SPK_MUL1,
		ST_SPK_MUL2,
		ST_TICK_RD,
		ST_TICK_WR,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLEAR,
		WR_DECAY
	} wr_kind_t;

	typedef struct packed {
		logic     latch;
		logic     cnt_clr;
		logic     cnt_inc;
		logic     rd_en;
		logic     rd_sel_cnt;
		wr_kind_t wr_kind;
		logic     mul1_en;
		logic     mul2_en;
		logic     fin;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/tsu_if.sv
// Valid/ready channel interfaces for request and result items.
interface tsu_in_if
	import tsu_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [SYN_W-1:0]  synapse;
	logic [WEIGHT_W-1:0] load_value;
	modport source (output valid, req_type, synapse, load_value, input ready);
	modport sink (input valid, req_type, synapse, load_value, output ready);
endinterface

interface tsu_out_if
	import tsu_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SYN_W-1:0]    synapse_out;
	logic [WEIGHT_W-1:0] weight_used;
	logic [WEIGHT_W-1:0] weight_new;
	modport source (output valid, synapse_out, weight_used, weight_new, input ready);
	modport sink (input valid, synapse_out, weight_used, weight_new, output ready);
endinterface

FILE: hw/rtl/tsu_cfg_regs.sv
// APB configuration register file holding decay factors and amplitudes.
module tsu_cfg_regs
	import tsu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [FACTOR_W-1:0] regs_q [CFG_NUM];
	logic [2:0]          idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign prdata = {{(PDATA_W-FACTOR_W){1'b0}}, regs_q[idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) regs_q[i] <= CFG_RESET[i];
		end else if (psel && penable && pwrite) begin
			regs_q[idx] <= pwdata[FACTOR_W-1:0];
		end
	end

	assign cfg.decay_fast_pre       = regs_q[CFG_DECAY_FAST_PRE];
	assign cfg.decay_slow_pre       = regs_q[CFG_DECAY_SLOW_PRE];
	assign cfg.decay_fast_post      = regs_q[CFG_DECAY_FAST_POST];
	assign cfg.decay_slow_post      = regs_q[CFG_DECAY_SLOW_POST];
	assign cfg.pair_potentiation    = regs_q[CFG_PAIR_POT];
	assign cfg.triplet_potentiation = regs_q[CFG_TRIPLET_POT];
	assign cfg.pair_depression      = regs_q[CFG_PAIR_DEP];
	assign cfg.triplet_depression   = regs_q[CFG_TRIPLET_DEP];

endmodule

FILE: hw/rtl/tsu_ctrl.sv
// Controller state machine sequencing clear, tick walks and spike updates.
module tsu_ctrl
	import tsu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_is_tick,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.cnt_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = in_is_tick ? ST_TICK_RD : ST_SPK_RD;
			end
			ST_SPK_RD:   state_nxt = ST_SPK_MUL1;
			ST_SPK_MUL1: state_nxt = ST_SPK_MUL2;
			ST_SPK_MUL2: state_nxt = ST_FIN;
			ST_TICK_RD:  state_nxt = ST_TICK_WR;
			ST_TICK_WR:  state_nxt = status.cnt_last ? ST_FIN : ST_TICK_RD;
			ST_FIN: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_kind = WR_CLEAR;
				cmd.cnt_inc = 1'b1;
				cmd.cnt_clr = status.cnt_last;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.latch   = in_valid;
				cmd.cnt_clr = in_valid;
			end
			ST_SPK_RD:   cmd.rd_en = 1'b1;
			ST_SPK_MUL1: cmd.mul1_en = 1'b1;
			ST_SPK_MUL2: cmd.mul2_en = 1'b1;
			ST_TICK_RD: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_sel_cnt = 1'b1;
			end
			ST_TICK_WR: begin
				cmd.wr_kind = WR_DECAY;
				cmd.cnt_inc = !status.cnt_last;
			end
			ST_FIN:  cmd.fin = status.out_free;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> status.out_free) else $error("result loaded into busy slot");
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && in_is_tick) |=> state_q == ST_TICK_RD)
		else $error("tick transfer did not start a walk");
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK_WR && status.cnt_last) |=> state_q == ST_FIN)
		else $error("tick walk did not end at the last synapse");
`endif

endmodule

FILE: hw/rtl/tsu_datapath.sv
// Datapath: synapse memory, decay and plasticity arithmetic, result register.
module tsu_datapath
	import tsu_pkg::*;
#(
	parameter int NUM_SYNAPSES = DEF_NUM_SYNAPSES,
	parameter int TRACE_BITS   = DEF_TRACE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  cfg_t                cfg,
	input  logic [1:0]          in_req_type,
	input  logic [SYN_W-1:0]    in_synapse,
	input  logic [WEIGHT_W-1:0] in_load_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SYN_W-1:0]    out_synapse,
	output logic [WEIGHT_W-1:0] out_weight_used,
	output logic [WEIGHT_W-1:0] out_weight_new
);

	localparam int TB  = TRACE_BITS;
	localparam int AW  = $clog2(NUM_SYNAPSES);
	localparam int MW  = WEIGHT_W + 4 * TB;
	localparam int QW  = 2 * TB - 16;
	localparam int DW  = ((TB > QW) ? TB : QW) + 1;
	localparam int CW  = (DW > WEIGHT_W + 1) ? DW : WEIGHT_W + 1;
	localparam int BW  = ((TB > WEIGHT_W) ? TB : WEIGHT_W) + 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_SYNAPSES - 1);
	localparam logic [TB-1:0] TMAX = {TB{1'b1}};

	logic [MW-1:0] mem [NUM_SYNAPSES];
	logic [MW-1:0] rd_q;
	logic [MW-1:0] wr_data;
	logic [AW-1:0] cnt_q, rd_addr, wr_addr, syn_addr;
	logic          wr_en;

	req_t                req_q;
	logic [SYN_W-1:0]    syn_q;
	logic [WEIGHT_W-1:0] load_q;
	logic                in_range;

	logic [QW-1:0] q_s1;
	logic [TB-1:0] p_s1;
	logic [DW-1:0] dw_s2;

	logic                out_valid_q;
	logic [SYN_W-1:0]    out_syn_q;
	logic [WEIGHT_W-1:0] out_used_q, out_new_q;

	// Word layout: weight, fast pre, slow pre, fast post, slow post.
	logic [WEIGHT_W-1:0] w_rd;
	logic [TB-1:0]       r1, r2, o1, o2;
	assign w_rd = rd_q[MW-1 -: WEIGHT_W];
	assign r1   = rd_q[4*TB-1 -: TB];
	assign r2   = rd_q[3*TB-1 -: TB];
	assign o1   = rd_q[2*TB-1 -: TB];
	assign o2   = rd_q[TB-1:0];

	assign syn_addr = AW'(syn_q);
	assign in_range = (32'(syn_q) < NUM_SYNAPSES);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= req_t'(in_req_type);
			syn_q  <= in_synapse;
			load_q <= in_load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end
	assign status.cnt_last = (cnt_q == LAST);

	function automatic logic [TB-1:0] decay(input logic [TB-1:0] t,
			input logic [FACTOR_W-1:0] f);
		logic [TB+15:0] m;
		m = t * f;
		return m[TB+15:16];
	endfunction

	function automatic logic [TB-1:0] bump(input logic [TB-1:0] t);
		logic [BW-1:0] s;
		s = BW'(t) + BW'(W_ONE);
		return (s > BW'(TMAX)) ? TMAX : s[TB-1:0];
	endfunction

	// First product stage: the triplet product and the pair term.
	logic [TB-1:0]       mx, my;
	logic [FACTOR_W-1:0] a2, a3;
	logic [2*TB-1:0]     xy;
	logic [TB+15:0]      a2x;
	always_comb begin
		if (req_q == REQ_PRE) begin
			mx = o1;
			my = r2;
			a2 = cfg.pair_depression;
			a3 = cfg.triplet_depression;
		end else begin
			mx = r1;
			my = o2;
			a2 = cfg.pair_potentiation;
			a3 = cfg.triplet_potentiation;
		end
		xy  = mx * my;
		a2x = a2 * mx;
	end

	logic [QW+15:0] a3q;
	assign a3q = a3 * q_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul1_en) begin
			q_s1 <= xy[2*TB-1:16];
			p_s1 <= a2x[TB+15:16];
		end
		if (cmd.mul2_en) begin
			dw_s2 <= DW'(p_s1) + DW'(a3q[QW+15:16]);
		end
	end

	// Final weight.
	logic [WEIGHT_W-1:0] w_old, w_new;
	logic [CW-1:0]       dwc, woc;
	always_comb begin
		w_old = (w_rd > W_ONE) ? W_ONE : w_rd;
		dwc   = CW'(dw_s2);
		woc   = CW'(w_old);
		case (req_q)
			REQ_PRE:  w_new = (dwc >= woc) ? '0 : WEIGHT_W'(woc - dwc);
			REQ_POST: w_new = (dwc >= CW'(W_ONE) - woc) ? W_ONE : WEIGHT_W'(woc + dwc);
			REQ_LOAD: w_new = (load_q > W_ONE) ? W_ONE : load_q;
			default:  w_new = '0;
		endcase
	end

	logic spike_wr;
	assign spike_wr = cmd.fin && in_range && (req_q != REQ_TICK);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = '0;
		case (cmd.wr_kind)
			WR_CLEAR: wr_en = 1'b1;
			WR_DECAY: begin
				wr_en   = 1'b1;
				wr_data = {w_rd, decay(r1, cfg.decay_fast_pre),
					decay(r2, cfg.decay_slow_pre), decay(o1, cfg.decay_fast_post),
					decay(o2, cfg.decay_slow_post)};
			end
			default: begin
				wr_en   = spike_wr;
				wr_addr = syn_addr;
				case (req_q)
					REQ_PRE:  wr_data = {w_new, bump(r1), bump(r2), o1, o2};
					REQ_POST: wr_data = {w_new, r1, r2, bump(o1), bump(o2)};
					default:  wr_data = {w_new, r1, r2, o1, o2};
				endcase
			end
		endcase
	end

	assign rd_addr = cmd.rd_sel_cnt ? cnt_q : syn_addr;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_q <= mem[rd_addr];
	end

	// Result register: a finished result waits here until its transfer.
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (req_q == REQ_TICK) begin
				out_syn_q  <= '0;
				out_used_q <= '0;
				out_new_q  <= '0;
			end else begin
				out_syn_q  <= syn_q;
				out_used_q <= in_range ? w_old : '0;
				out_new_q  <= in_range ? w_new : '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_synapse     = out_syn_q;
	assign out_weight_used = out_used_q;
	assign out_weight_new  = out_new_q;

endmodule

FILE: hw/rtl/triplet_stdp_synapse_update.sv
// Top level of the triplet STDP synapse update block.
//
//  channel | direction | handshake     | payload
//  in_ch   | in        | valid/ready   | req_type, synapse, load_value
//  out_ch  | out       | valid/ready   | synapse_out, weight_used, weight_new
//  apb     | in        | psel/penable  | paddr, pwdata, prdata
//
// A spike or load item passes through a memory read, two multiply stages and
// the write-back. A tick walks every synapse, reading each word and writing
// it back with decayed traces. After reset the memory is cleared with no item
// taken. A stalled result waits in the output register; the next item is taken meanwhile.
module triplet_stdp_synapse_update
	import tsu_pkg::*;
#(
	parameter int NUM_SYNAPSES = DEF_NUM_SYNAPSES,
	parameter int TRACE_BITS   = DEF_TRACE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	tsu_in_if.sink             in_ch,
	tsu_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	tsu_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	tsu_ctrl u_ctrl (
		.clk,
		.arst_n,
		.in_valid   (in_ch.valid),
		.in_is_tick (in_ch.req_type == REQ_TICK),
		.in_ready   (in_ch.ready),
		.status,
		.cmd
	);

	tsu_datapath #(
		.NUM_SYNAPSES (NUM_SYNAPSES),
		.TRACE_BITS   (TRACE_BITS)
	) u_dp (
		.clk,
		.arst_n,
		.cmd,
		.status,
		.cfg,
		.in_req_type     (in_ch.req_type),
		.in_synapse      (in_ch.synapse),
		.in_load_value   (in_ch.load_value),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.out_synapse     (out_ch.synapse_out),
		.out_weight_used (out_ch.weight_used),
		.out_weight_new  (out_ch.weight_new)
	);

endmodule
